[rtl/fip_pkg.sv]
// Shared types and constants for the integer power unit.
// No dependencies; imported by every other module of the block.
package fip_pkg;

   // Double precision field constants
   localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;

   // Which operation the shared float unit runs
   typedef enum logic {
      FOP_MUL,
      FOP_RECIP
   } fip_op_type;

   // Operand and destination selection for one float operation
   typedef enum logic [1:0] {
      SEL_PROD,   // product * square -> product
      SEL_SQ,     // square * square  -> square
      SEL_RECIP   // 1.0 / product    -> product
   } fip_sel_type;

   typedef struct packed {
      logic        load;       // take a new request
      logic        fpu_start;  // launch one float operation
      fip_sel_type sel;
      logic        shift_mag;  // drop the lowest magnitude bit
      logic        load_out;   // move product into the response register
   } fip_cmd_type;

   typedef struct packed {
      logic mag_zero;
      logic mag_lsb;
      logic mag_last;   // only the lowest bit can still be set
      logic negative;
      logic fpu_done;
   } fip_status_type;

endpackage

[rtl/float_integer_power.sv]
// Top level of the double-precision integer power unit.
// Depends on fip_pkg, fip_ctrl, fip_datapath (and fip_fpu below it).
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_stall | req_base_bits, req_exponent
//   rsp     | out       | rsp_valid / rsp_stall | rsp_power_bits
//
// One request at a time. A multiply on the shared float unit takes longer when an operand
// or the result is subnormal. A request holds the block through one multiply per set bit
// of its exponent's magnitude and one square per bit below the top one, plus a reciprocal
// when the exponent is negative.
// Synchronous active-high reset clears the controller and the response valid.
// The response sits in its own register; a new request is taken while it is stalled.
module float_integer_power #(
   parameter int EXP_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [63:0]                 req_base_bits,
   input  logic signed [EXP_WIDTH-1:0] req_exponent,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_power_bits
);
   import fip_pkg::*;

   fip_cmd_type    cmd;
   fip_status_type status;

   // sequencer: square-and-multiply walk over the magnitude bits
   fip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, float unit and response register
   fip_datapath #(
      .EXP_WIDTH (EXP_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .base_bits  (req_base_bits),
      .exponent   (req_exponent),
      .power_bits (rsp_power_bits)
   );

endmodule

[rtl/fip_fpu.sv]
// Multi-cycle IEEE-754 double unit: multiply and reciprocal, round to nearest even.
// Depends on fip_pkg.
module fip_fpu (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fip_pkg::fip_op_type op,
   input  logic [63:0]       a,
   input  logic [63:0]       b,
   output logic              done,
   output logic [63:0]       result
);
   import fip_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE,
      F_NORM,
      F_MULP,
      F_DIV,
      F_PREP,
      F_DENORM,
      F_ROUND
   } fstate_type;

   fstate_type         state_ff, state_in;
   fip_op_type         op_ff, op_in;
   logic               sign_ff, sign_in;
   logic [52:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic signed [13:0] ea_ff, ea_in, eb_ff, eb_in;
   logic [105:0]       acc_ff, acc_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [53:0]        rem_ff, rem_in;
   logic [55:0]        quo_ff, quo_in;
   logic [52:0]        mant_ff, mant_in;
   logic               g_ff, g_in, st_ff, st_in;
   logic signed [13:0] e_ff, e_in;
   logic [63:0]        res_ff, res_in;
   logic               done_ff, done_in;

   // operand classification
   logic [10:0] ae, be;
   logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   // partial product
   logic [26:0]  pa, pb;
   logic [53:0]  pp;
   logic [105:0] pp_sh;
   // division step
   logic         ge;
   logic [53:0]  diff;
   // rounding
   logic               up;
   logic [53:0]        rsum;
   logic [52:0]        rm;
   logic signed [13:0] re;

   assign ae     = a[62:52];
   assign be     = b[62:52];
   assign a_nan  = (ae == EXP_ALL_ONE) && (a[51:0] != 52'd0);
   assign a_inf  = (ae == EXP_ALL_ONE) && (a[51:0] == 52'd0);
   assign a_zero = (ae == 11'd0) && (a[51:0] == 52'd0);
   assign b_nan  = (be == EXP_ALL_ONE) && (b[51:0] != 52'd0);
   assign b_inf  = (be == EXP_ALL_ONE) && (b[51:0] == 52'd0);
   assign b_zero = (be == 11'd0) && (b[51:0] == 52'd0);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: begin
            pa = ma_ff[26:0];
            pb = mb_ff[26:0];
         end
         2'd1: begin
            pa = ma_ff[26:0];
            pb = {1'b0, mb_ff[52:27]};
         end
         2'd2: begin
            pa = {1'b0, ma_ff[52:27]};
            pb = mb_ff[26:0];
         end
         default: begin
            pa = {1'b0, ma_ff[52:27]};
            pb = {1'b0, mb_ff[52:27]};
         end
      endcase
   end

   assign pp = pa * pb;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pp_sh = {52'd0, pp};
         2'd3:    pp_sh = {pp, 52'd0} << 2;
         default: pp_sh = {25'd0, pp, 27'd0};
      endcase
   end

   assign ge   = rem_ff >= {1'b0, ma_ff};
   assign diff = rem_ff - {1'b0, ma_ff};

   assign up   = g_ff & (st_ff | mant_ff[0]);
   assign rsum = {1'b0, mant_ff} + {53'd0, up};
   assign rm   = rsum[53] ? {1'b1, 52'd0} : rsum[52:0];
   assign re   = rsum[53] ? e_ff + 14'sd1 : e_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      sign_in  = sign_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      ea_in    = ea_ff;
      eb_in    = eb_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mant_in  = mant_ff;
      g_in     = g_ff;
      st_in    = st_ff;
      e_in     = e_ff;
      res_in   = res_ff;
      done_in  = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (start) begin
               op_in = op;
               ma_in = {ae != 11'd0, a[51:0]};
               ea_in = (ae == 11'd0) ? 14'sd1 : $signed({3'd0, ae});
               if (op == FOP_MUL) begin
                  sign_in = a[63] ^ b[63];
                  mb_in   = {be != 11'd0, b[51:0]};
                  eb_in   = (be == 11'd0) ? 14'sd1 : $signed({3'd0, be});
                  if (a_nan) begin
                     res_in  = a | QUIET_BIT;
                     done_in = 1'b1;
                  end else if (b_nan) begin
                     res_in  = b | QUIET_BIT;
                     done_in = 1'b1;
                  end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                     res_in  = DEFAULT_NAN;
                     done_in = 1'b1;
                  end else if (a_inf || b_inf) begin
                     res_in  = {a[63] ^ b[63], EXP_ALL_ONE, 52'd0};
                     done_in = 1'b1;
                  end else if (a_zero || b_zero) begin
                     res_in  = {a[63] ^ b[63], 63'd0};
                     done_in = 1'b1;
                  end else begin
                     state_in = F_NORM;
                  end
               end else begin
                  sign_in = a[63];
                  mb_in   = {1'b1, 52'd0};
                  eb_in   = 14'sd1;
                  if (a_nan) begin
                     res_in  = a | QUIET_BIT;
                     done_in = 1'b1;
                  end else if (a_inf) begin
                     res_in  = {a[63], 63'd0};
                     done_in = 1'b1;
                  end else if (a_zero) begin
                     res_in  = {a[63], EXP_ALL_ONE, 52'd0};
                     done_in = 1'b1;
                  end else begin
                     state_in = F_NORM;
                  end
               end
            end
         end
         F_NORM: begin
            // one bit of subnormal normalisation per cycle
            if (!ma_ff[52]) begin
               ma_in = ma_ff << 1;
               ea_in = ea_ff - 14'sd1;
            end
            if (!mb_ff[52]) begin
               mb_in = mb_ff << 1;
               eb_in = eb_ff - 14'sd1;
            end
            if (ma_ff[52] && mb_ff[52]) begin
               cnt_in = 6'd0;
               if (op_ff == FOP_MUL) begin
                  acc_in   = 106'd0;
                  state_in = F_MULP;
               end else begin
                  rem_in   = {2'b01, 52'd0};
                  quo_in   = 56'd0;
                  state_in = F_DIV;
               end
            end
         end
         F_MULP: begin
            acc_in = acc_ff + pp_sh;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = F_PREP;
            end
         end
         F_DIV: begin
            quo_in = {quo_ff[54:0], ge};
            rem_in = (ge ? diff : rem_ff) << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               state_in = F_PREP;
            end
         end
         F_PREP: begin
            if (op_ff == FOP_MUL) begin
               if (acc_ff[105]) begin
                  mant_in = acc_ff[105:53];
                  g_in    = acc_ff[52];
                  st_in   = |acc_ff[51:0];
                  e_in    = ea_ff + eb_ff - 14'sd1022;
               end else begin
                  mant_in = acc_ff[104:52];
                  g_in    = acc_ff[51];
                  st_in   = |acc_ff[50:0];
                  e_in    = ea_ff + eb_ff - 14'sd1023;
               end
            end else begin
               if (quo_ff[55]) begin
                  mant_in = quo_ff[55:3];
                  g_in    = quo_ff[2];
                  st_in   = (|quo_ff[1:0]) | (rem_ff != 54'd0);
                  e_in    = 14'sd2046 - ea_ff;
               end else begin
                  mant_in = quo_ff[54:2];
                  g_in    = quo_ff[1];
                  st_in   = quo_ff[0] | (rem_ff != 54'd0);
                  e_in    = 14'sd2045 - ea_ff;
               end
            end
            state_in = F_DENORM;
         end
         F_DENORM: begin
            // right shift into the subnormal range, one bit per cycle
            if (e_ff < 14'sd1) begin
               if ((mant_ff == 53'd0) && !g_ff) begin
                  e_in = 14'sd1;
               end else begin
                  st_in   = st_ff | g_ff;
                  g_in    = mant_ff[0];
                  mant_in = mant_ff >> 1;
                  e_in    = e_ff + 14'sd1;
               end
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (re >= 14'sd2047) begin
               res_in = {sign_ff, EXP_ALL_ONE, 52'd0};
            end else begin
               res_in = {sign_ff, rm[52] ? re[10:0] : 11'd0, rm[51:0]};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      sign_ff <= sign_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mant_ff <= mant_in;
      g_ff    <= g_in;
      st_ff   <= st_in;
      e_ff    <= e_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[rtl/fip_datapath.sv]
// Datapath: square, product and magnitude registers around the shared float unit.
// Depends on fip_pkg and fip_fpu.
module fip_datapath #(
   parameter int EXP_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fip_pkg::fip_cmd_type        cmd,
   output fip_pkg::fip_status_type     status,
   input  logic [63:0]                 base_bits,
   input  logic signed [EXP_WIDTH-1:0] exponent,
   output logic [63:0]                 power_bits
);
   import fip_pkg::*;

   logic [63:0]          square_ff, product_ff, power_ff;
   logic [EXP_WIDTH-1:0] mag_ff;
   logic                 neg_ff;
   fip_sel_type          sel_ff;
   logic                 fpu_done;
   logic [63:0]          fpu_a, fpu_result;
   fip_op_type           fpu_op;

   assign fpu_a  = (cmd.sel == SEL_SQ) ? square_ff : product_ff;
   assign fpu_op = (cmd.sel == SEL_RECIP) ? FOP_RECIP : FOP_MUL;

   fip_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.fpu_start),
      .op     (fpu_op),
      .a      (fpu_a),
      .b      (square_ff),
      .done   (fpu_done),
      .result (fpu_result)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         square_ff  <= base_bits;
         product_ff <= ONE_BITS;
         neg_ff     <= exponent[EXP_WIDTH-1];
         mag_ff     <= exponent[EXP_WIDTH-1] ? (~exponent + 1'b1) : exponent;
      end else begin
         if (cmd.shift_mag) begin
            mag_ff <= mag_ff >> 1;
         end
         if (fpu_done) begin
            if (sel_ff == SEL_SQ) begin
               square_ff <= fpu_result;
            end else begin
               product_ff <= fpu_result;
            end
         end
      end
      if (cmd.fpu_start) begin
         sel_ff <= cmd.sel;
      end
      if (cmd.load_out) begin
         power_ff <= product_ff;
      end
   end

   assign status.mag_zero = (mag_ff == '0);
   assign status.mag_lsb  = mag_ff[0];
   assign status.mag_last = ((mag_ff >> 1) == '0);
   assign status.negative = neg_ff;
   assign status.fpu_done = fpu_done;
   assign power_bits      = power_ff;

endmodule

[rtl/fip_ctrl.sv]
// Controller: walks the exponent magnitude and sequences the float unit.
// Depends on fip_pkg.
module fip_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  fip_pkg::fip_status_type status,
   output fip_pkg::fip_cmd_type    cmd
);
   import fip_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PWAIT,
      S_SWAIT,
      S_RWAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.fpu_start = 1'b0;
      cmd.sel       = SEL_PROD;
      cmd.shift_mag = 1'b0;
      cmd.load_out  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.mag_zero) begin
               if (status.negative) begin
                  cmd.fpu_start = 1'b1;
                  cmd.sel       = SEL_RECIP;
                  state_in      = S_RWAIT;
               end else begin
                  state_in = S_OUT;
               end
            end else if (status.mag_lsb) begin
               cmd.fpu_start = 1'b1;
               cmd.sel       = SEL_PROD;
               state_in      = S_PWAIT;
            end else begin
               cmd.fpu_start = 1'b1;
               cmd.sel       = SEL_SQ;
               state_in      = S_SWAIT;
            end
         end
         S_PWAIT: begin
            if (status.fpu_done) begin
               if (status.mag_last) begin
                  cmd.shift_mag = 1'b1;
                  state_in      = S_CHECK;
               end else begin
                  cmd.fpu_start = 1'b1;
                  cmd.sel       = SEL_SQ;
                  state_in      = S_SWAIT;
               end
            end
         end
         S_SWAIT: begin
            if (status.fpu_done) begin
               cmd.shift_mag = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_RWAIT: begin
            if (status.fpu_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[dv/float_integer_power_test.sv]
// Self-checking testbench for float_integer_power: double base to a signed integer power.
// Depends only on the block's RTL (float_integer_power and the modules and fip_pkg it pulls in).
module float_integer_power_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HALF_PERIOD = 10;
   localparam int          N_RANDOM    = 1030;
   localparam int          DRAIN_WAIT  = 8000;      // worst request: ~64 ops, subnormal slow paths
   localparam longint      CYCLE_LIMIT = 12_000_000;
   localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] UNIT_BITS   = 64'h3FF0_0000_0000_0000;

   // One pending request plus how the driver should treat it
   typedef struct {
      logic [63:0] base_bits;
      int          exponent;
      bit          drain_first;   // hold off until every result is back
      bit          no_idle;       // neither side idles around this one
   } power_req_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [63:0] req_base_bits  = '0;
   logic signed [31:0] req_exponent = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [63:0] rsp_power_bits;

   power_req_type pending_reqs[$];
   logic [63:0] expected_powers[$];
   int          mismatches  = 0;
   int          req_gap     = 0;
   int          rsp_wait    = 0;
   bit          req_taken   = 1'b0;
   bit          quiet_phase = 1'b0;
   longint      cycle_count = 0;

   float_integer_power i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_base_bits  (req_base_bits),
      .req_exponent   (req_exponent),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_power_bits (rsp_power_bits)
   );

   always #HALF_PERIOD clock = ~clock;

   // Square-and-multiply over the exponent's magnitude; the host's doubles
   // round to nearest even exactly as the block must.
   function automatic logic [63:0] integer_power(logic [63:0] base_bits, int exponent);
      logic [31:0] mag;
      real         square;
      real         product;
      logic [63:0] pbits;
      mag     = (exponent < 0) ? -exponent : exponent;   // most negative walks as 2^31
      square  = $bitstoreal(base_bits);
      product = 1.0;
      while (mag != 0) begin
         if (mag[0]) product = product * square;
         square = square * square;
         mag    = mag >> 1;
      end
      pbits = $realtobits(product);
      if (exponent < 0) begin
         // 1/±0 gives an infinity carrying the zero's sign
         if (pbits[62:0] == '0) pbits = (pbits & SIGN_BIT) | POS_INF;
         else pbits = $realtobits(1.0 / product);
      end
      return pbits;
   endfunction

   function automatic int draw_wait();
      return quiet_phase ? 0 : $urandom_range(0, 7);
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("mismatch @%0t: %s", $realtime, what);
   endtask

   // Bases spread over the interesting corners of the double format
   function automatic logic [63:0] random_base();
      logic [63:0] b;
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b[62:52] = 11'(11'h3FF + $urandom_range(0, 6) - 3);  // near one
         4:          b[62:52] = 11'(11'h3FE + $urandom_range(0, 1));
         5:          b[62:52] = 11'h000;                              // subnormal or zero
         6:          b[62:52] = 11'h7FF;                              // infinity or NaN
         7:          b[51:0]  = '0;                                   // powers of two
         default: ;                                                   // anything at all
      endcase
      return b;
   endfunction

   function automatic int random_exponent();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 80) - 40;
         5, 6:          return $urandom_range(0, 2000) - 1000;
         default:       return int'($urandom);
      endcase
   endfunction

   task automatic queue_req(logic [63:0] b, int e, bit drain = 0, bit calm = 0);
      power_req_type r;
      r.base_bits   = b;
      r.exponent    = e;
      r.drain_first = drain;
      r.no_idle     = calm;
      pending_reqs.push_back(r);
   endtask

   // Stimulus: directed corners, then random requests with the odd drain and calm stretch
   initial begin
      queue_req(64'h7FF8_0000_0000_0001, 0);               // zero exponent on a NaN
      queue_req(64'hFFF0_0000_0000_0000, 0);
      queue_req(UNIT_BITS, 1);
      queue_req(64'h4000_0000_0000_0000, 10);
      queue_req(64'h4000_0000_0000_0000, -10);
      queue_req(64'hBFF0_0000_0000_0000, -2147483648);      // most negative exponent
      queue_req(64'hBFF0_0000_0000_0000, 2147483647);       // most positive exponent
      queue_req(64'h3FF0_0000_0000_0001, -2147483648);
      queue_req(64'h0000_0000_0000_0000, -3);               // reciprocal of +0
      queue_req(64'h8000_0000_0000_0000, -1);               // reciprocal of -0
      queue_req(64'h8000_0000_0000_0000, -2);
      queue_req(64'h0010_0000_0000_0000, -2);               // product underflows, then 1/0
      queue_req(64'h0000_0000_0000_0001, 1);                // smallest subnormal
      queue_req(64'h000F_FFFF_FFFF_FFFF, 2);
      queue_req(64'h000F_FFFF_FFFF_FFFF, -1);
      queue_req(64'h7FEF_FFFF_FFFF_FFFF, 2);                // overflow to infinity
      queue_req(64'h7FEF_FFFF_FFFF_FFFF, -1);
      queue_req(64'hFFF0_0000_0000_0000, -3);               // reciprocal of -inf
      queue_req(64'h7FF0_0000_0000_0000, 3);
      queue_req(64'hFFF4_0000_0000_0000, 5);                // signalling NaN in
      queue_req(64'h3FE0_0000_0000_0000, 1074);             // lands on a subnormal
      queue_req(64'hC000_0000_0000_0000, -1023);
      queue_req(64'hFFFF_FFFF_FFFF_FFFF, -7, 1);
      for (int i = 0; i < N_RANDOM; i++)
         queue_req(random_base(), random_exponent(), (i % 250) == 249, (i / 40) % 6 == 3);

      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_powers.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_powers.size() == 0)
         $display("[ OK ] regression clean");
      else begin
         if (expected_powers.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_powers.size()));
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Request driver: payload moves on the falling edge, held while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // still waiting for acceptance: hold everything
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first &&
                        (expected_powers.size() != 0 || req_taken))) begin
            power_req_type r;
            r = pending_reqs.pop_front();
            quiet_phase   = r.no_idle;
            req_base_bits <= r.base_bits;
            req_exponent  <= r.exponent;
            req_valid     <= 1'b1;
            req_gap       <= draw_wait();
         end else begin
            req_valid <= 1'b0;
         end
         // response back-pressure
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait  <= rsp_wait - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: predicts on acceptance, checks results in order
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_powers.push_back(integer_power(req_base_bits, req_exponent));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_wait <= draw_wait();
            if (expected_powers.size() == 0)
               report_mismatch($sformatf("unexpected result %h", rsp_power_bits));
            else begin
               logic [63:0] want;
               want = expected_powers.pop_front();
               if (rsp_power_bits !== want)
                  report_mismatch($sformatf("power_bits %h, expected %h",
                                            rsp_power_bits, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

[filelist.f]
rtl/fip_pkg.sv
rtl/fip_fpu.sv
rtl/fip_datapath.sv
rtl/fip_ctrl.sv
rtl/float_integer_power.sv
dv/float_integer_power_test.sv
